// File: src/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TFS_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TFS_ASSERT(lbl, clk, rst_n, prop, msg)

`define TFS_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: src/tfs_pkg.sv
// Constants, types and codes of the two-level FCFS scheduler.
package tfs_pkg;

  localparam int MAX_PROCS    = 16;
  localparam int TIME_IN_BITS = 16;

  localparam int IN_W    = 16;
  localparam int TIME_W  = (TIME_IN_BITS < IN_W) ? TIME_IN_BITS : IN_W;
  localparam int IDX_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W   = $clog2(MAX_PROCS + 1);
  localparam int PID_W   = 4;
  localparam int T_W     = 21;
  localparam int S_W     = 25;
  localparam int ENTRY_W = 2 * TIME_W + 1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PICK,
    ST_FIN,
    ST_TAT,
    ST_WT,
    ST_WSUM,
    ST_TSUM,
    ST_OUT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t        op;
    logic [S_W-1:0] a;
    logic [S_W-1:0] b;
  } alu_req_t;

endpackage

// File: src/tfs_if.sv
// Record and result channel interfaces of the scheduler.
interface tfs_in_if;
  logic                      valid;
  logic                      ready;
  logic [tfs_pkg::IN_W-1:0]  burst;
  logic [tfs_pkg::IN_W-1:0]  arrival;
  logic                      is_system;
  logic                      last_item;

  modport source(output valid, burst, arrival, is_system, last_item, input ready);
  modport sink(input valid, burst, arrival, is_system, last_item, output ready);
endinterface

interface tfs_out_if;
  logic                       valid;
  logic                       ready;
  logic [tfs_pkg::PID_W-1:0]  pid;
  logic                       sys_class;
  logic [tfs_pkg::T_W-1:0]    run_start;
  logic [tfs_pkg::T_W-1:0]    finish_time;
  logic [tfs_pkg::T_W-1:0]    turnaround;
  logic [tfs_pkg::T_W-1:0]    wait_res;
  logic [tfs_pkg::S_W-1:0]    total_wait;
  logic [tfs_pkg::S_W-1:0]    total_turnaround;
  logic                       final_result;

  modport source(output valid, pid, sys_class, run_start, finish_time, turnaround,
                 wait_res, total_wait, total_turnaround, final_result, input ready);
  modport sink(input valid, pid, sys_class, run_start, finish_time, turnaround,
               wait_res, total_wait, total_turnaround, final_result, output ready);
endinterface

// File: src/tfs_ram.sv
// Single-write, single-read RAM with registered read data.
module tfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/tfs_alu.sv
// Shared add/subtract unit for schedule arithmetic.
module tfs_alu (
  input  tfs_pkg::alu_req_t         req,
  output logic [tfs_pkg::S_W-1:0]   res
);

  always_comb begin
    case (req.op)
      tfs_pkg::ALU_ADD: res = req.a + req.b;
      tfs_pkg::ALU_SUB: res = req.a - req.b;
      default:          res = req.a;
    endcase
  end

endmodule

// File: src/two_level_fcfs_scheduler_unit.sv
// Two-level non-preemptive FCFS scheduler: top level with sequencer and datapath.
//
// Records load at one per cycle while in_ch.ready is high; the record flagged
// last_item starts the schedule and ready stays low until the last result is
// taken. For each result the sequencer streams the one-read-port record store
// through the compare logic, picks a record, uses the shared adder in turn for
// finish, turnaround, wait and the two running sums, and then presents the
// result until out_ch.ready takes it.
`include "assert_macros.svh"

module two_level_fcfs_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  tfs_in_if.sink      in_ch,
  tfs_out_if.source   out_ch
);

  localparam int TW = tfs_pkg::TIME_W;
  localparam int IW = tfs_pkg::IDX_W;
  localparam int CW = tfs_pkg::CNT_W;
  localparam int T  = tfs_pkg::T_W;
  localparam int S  = tfs_pkg::S_W;

  tfs_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [tfs_pkg::MAX_PROCS-1:0] done_r, done_nxt;
  logic [T-1:0]  now_r, now_nxt;
  logic [S-1:0]  wsum_r, wsum_nxt;
  logic [S-1:0]  tsum_r, tsum_nxt;

  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic          issue_r, issue_nxt;
  logic          cmp_valid_r, cmp_valid_nxt;
  logic          cmp_last_r, cmp_last_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;

  logic          sys_found_r, sys_found_nxt;
  logic [TW-1:0] sys_arr_r, sys_arr_nxt;
  logic [TW-1:0] sys_bur_r, sys_bur_nxt;
  logic [IW-1:0] sys_idx_r, sys_idx_nxt;
  logic          usr_found_r, usr_found_nxt;
  logic [TW-1:0] usr_arr_r, usr_arr_nxt;
  logic [TW-1:0] usr_bur_r, usr_bur_nxt;
  logic [IW-1:0] usr_idx_r, usr_idx_nxt;

  logic [IW-1:0] sel_idx_r, sel_idx_nxt;
  logic          sel_cls_r, sel_cls_nxt;
  logic [TW-1:0] sel_arr_r, sel_arr_nxt;
  logic [TW-1:0] sel_bur_r, sel_bur_nxt;
  logic [T-1:0]  start_r, start_nxt;
  logic [T-1:0]  finish_r, finish_nxt;
  logic [T-1:0]  tat_r, tat_nxt;
  logic [T-1:0]  wt_r, wt_nxt;
  logic          final_r, final_nxt;

  logic                      ram_we;
  logic [tfs_pkg::ENTRY_W-1:0] ram_wdata;
  logic [tfs_pkg::ENTRY_W-1:0] ram_rdata;
  logic [TW-1:0]             rd_arr;
  logic [TW-1:0]             rd_bur;
  logic                      rd_cls;

  tfs_pkg::alu_req_t alu_req;
  logic [S-1:0]      alu_res;

  logic          sys_rdy;
  logic          usr_rdy;
  logic [TW-1:0] jmp_arr;
  logic [T-1:0]  pick_now;
  logic          take_sys;
  logic          final_xfer;

  assign ram_wdata = {in_ch.is_system, in_ch.arrival[TW-1:0], in_ch.burst[TW-1:0]};
  assign {rd_cls, rd_arr, rd_bur} = ram_rdata;
  assign ram_we = (state_r == tfs_pkg::ST_LOAD) && in_ch.valid &&
                  (cnt_r < CW'(tfs_pkg::MAX_PROCS));

  tfs_ram #(
    .WIDTH(tfs_pkg::ENTRY_W),
    .DEPTH(tfs_pkg::MAX_PROCS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IW-1:0]),
    .wdata (ram_wdata),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  tfs_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign sys_rdy  = sys_found_r && (T'(sys_arr_r) <= now_r);
  assign usr_rdy  = usr_found_r && (T'(usr_arr_r) <= now_r);
  assign jmp_arr  = (sys_found_r && (!usr_found_r || sys_arr_r <= usr_arr_r)) ?
                    sys_arr_r : usr_arr_r;
  assign pick_now = (sys_rdy || usr_rdy) ? now_r : T'(jmp_arr);
  assign take_sys = sys_found_r && (T'(sys_arr_r) <= pick_now);

  assign final_xfer = out_ch.valid && out_ch.ready && final_r;

  assign in_ch.ready = (state_r == tfs_pkg::ST_LOAD);

  assign out_ch.valid            = (state_r == tfs_pkg::ST_OUT);
  assign out_ch.pid              = tfs_pkg::PID_W'(sel_idx_r);
  assign out_ch.sys_class        = sel_cls_r;
  assign out_ch.run_start        = start_r;
  assign out_ch.finish_time      = finish_r;
  assign out_ch.turnaround       = tat_r;
  assign out_ch.wait_res         = wt_r;
  assign out_ch.total_wait       = wsum_r;
  assign out_ch.total_turnaround = tsum_r;
  assign out_ch.final_result     = final_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    done_nxt      = done_r;
    now_nxt       = now_r;
    wsum_nxt      = wsum_r;
    tsum_nxt      = tsum_r;
    scan_idx_nxt  = scan_idx_r;
    issue_nxt     = issue_r;
    cmp_valid_nxt = 1'b0;
    cmp_last_nxt  = 1'b0;
    cmp_idx_nxt   = scan_idx_r;
    sys_found_nxt = sys_found_r;
    sys_arr_nxt   = sys_arr_r;
    sys_bur_nxt   = sys_bur_r;
    sys_idx_nxt   = sys_idx_r;
    usr_found_nxt = usr_found_r;
    usr_arr_nxt   = usr_arr_r;
    usr_bur_nxt   = usr_bur_r;
    usr_idx_nxt   = usr_idx_r;
    sel_idx_nxt   = sel_idx_r;
    sel_cls_nxt   = sel_cls_r;
    sel_arr_nxt   = sel_arr_r;
    sel_bur_nxt   = sel_bur_r;
    start_nxt     = start_r;
    finish_nxt    = finish_r;
    tat_nxt       = tat_r;
    wt_nxt        = wt_r;
    final_nxt     = final_r;
    alu_req.op    = tfs_pkg::ALU_ADD;
    alu_req.a     = '0;
    alu_req.b     = '0;

    case (state_r)
      tfs_pkg::ST_LOAD: begin
        if (in_ch.valid) begin
          if (ram_we) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_ch.last_item) begin
            k_nxt         = '0;
            scan_idx_nxt  = '0;
            issue_nxt     = 1'b1;
            sys_found_nxt = 1'b0;
            usr_found_nxt = 1'b0;
            state_nxt     = tfs_pkg::ST_SCAN;
          end
        end
      end
      tfs_pkg::ST_SCAN: begin
        if (issue_r) begin
          cmp_valid_nxt = 1'b1;
          if (CW'(scan_idx_r) == cnt_r - CW'(1)) begin
            issue_nxt    = 1'b0;
            cmp_last_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + IW'(1);
          end
        end
        if (cmp_valid_r && !done_r[cmp_idx_r]) begin
          if (rd_cls) begin
            if (!sys_found_r || rd_arr < sys_arr_r) begin
              sys_found_nxt = 1'b1;
              sys_arr_nxt   = rd_arr;
              sys_bur_nxt   = rd_bur;
              sys_idx_nxt   = cmp_idx_r;
            end
          end else begin
            if (!usr_found_r || rd_arr < usr_arr_r) begin
              usr_found_nxt = 1'b1;
              usr_arr_nxt   = rd_arr;
              usr_bur_nxt   = rd_bur;
              usr_idx_nxt   = cmp_idx_r;
            end
          end
        end
        if (cmp_valid_r && cmp_last_r) begin
          state_nxt = tfs_pkg::ST_PICK;
        end
      end
      tfs_pkg::ST_PICK: begin
        now_nxt   = pick_now;
        start_nxt = pick_now;
        if (take_sys) begin
          sel_idx_nxt = sys_idx_r;
          sel_cls_nxt = 1'b1;
          sel_arr_nxt = sys_arr_r;
          sel_bur_nxt = sys_bur_r;
        end else begin
          sel_idx_nxt = usr_idx_r;
          sel_cls_nxt = 1'b0;
          sel_arr_nxt = usr_arr_r;
          sel_bur_nxt = usr_bur_r;
        end
        state_nxt = tfs_pkg::ST_FIN;
      end
      tfs_pkg::ST_FIN: begin
        alu_req.op = tfs_pkg::ALU_ADD;
        alu_req.a  = S'(start_r);
        alu_req.b  = S'(sel_bur_r);
        finish_nxt = alu_res[T-1:0];
        now_nxt    = alu_res[T-1:0];
        state_nxt  = tfs_pkg::ST_TAT;
      end
      tfs_pkg::ST_TAT: begin
        alu_req.op = tfs_pkg::ALU_SUB;
        alu_req.a  = S'(finish_r);
        alu_req.b  = S'(sel_arr_r);
        tat_nxt    = alu_res[T-1:0];
        state_nxt  = tfs_pkg::ST_WT;
      end
      tfs_pkg::ST_WT: begin
        alu_req.op = tfs_pkg::ALU_SUB;
        alu_req.a  = S'(tat_r);
        alu_req.b  = S'(sel_bur_r);
        wt_nxt     = alu_res[T-1:0];
        state_nxt  = tfs_pkg::ST_WSUM;
      end
      tfs_pkg::ST_WSUM: begin
        alu_req.op = tfs_pkg::ALU_ADD;
        alu_req.a  = wsum_r;
        alu_req.b  = S'(wt_r);
        wsum_nxt   = alu_res;
        state_nxt  = tfs_pkg::ST_TSUM;
      end
      tfs_pkg::ST_TSUM: begin
        alu_req.op           = tfs_pkg::ALU_ADD;
        alu_req.a            = tsum_r;
        alu_req.b            = S'(tat_r);
        tsum_nxt             = alu_res;
        done_nxt[sel_idx_r]  = 1'b1;
        final_nxt            = (k_r == cnt_r - CW'(1));
        state_nxt            = tfs_pkg::ST_OUT;
      end
      tfs_pkg::ST_OUT: begin
        if (out_ch.ready) begin
          if (final_r) begin
            cnt_nxt   = '0;
            done_nxt  = '0;
            now_nxt   = '0;
            wsum_nxt  = '0;
            tsum_nxt  = '0;
            state_nxt = tfs_pkg::ST_LOAD;
          end else begin
            k_nxt         = k_r + CW'(1);
            scan_idx_nxt  = '0;
            issue_nxt     = 1'b1;
            sys_found_nxt = 1'b0;
            usr_found_nxt = 1'b0;
            state_nxt     = tfs_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = tfs_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tfs_pkg::ST_LOAD;
      cnt_r       <= '0;
      k_r         <= '0;
      done_r      <= '0;
      now_r       <= '0;
      wsum_r      <= '0;
      tsum_r      <= '0;
      issue_r     <= 1'b0;
      cmp_valid_r <= 1'b0;
      cmp_last_r  <= 1'b0;
      sys_found_r <= 1'b0;
      usr_found_r <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      done_r      <= done_nxt;
      now_r       <= now_nxt;
      wsum_r      <= wsum_nxt;
      tsum_r      <= tsum_nxt;
      issue_r     <= issue_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      cmp_last_r  <= cmp_last_nxt;
      sys_found_r <= sys_found_nxt;
      usr_found_r <= usr_found_nxt;
      final_r     <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    sys_arr_r  <= sys_arr_nxt;
    sys_bur_r  <= sys_bur_nxt;
    sys_idx_r  <= sys_idx_nxt;
    usr_arr_r  <= usr_arr_nxt;
    usr_bur_r  <= usr_bur_nxt;
    usr_idx_r  <= usr_idx_nxt;
    sel_idx_r  <= sel_idx_nxt;
    sel_cls_r  <= sel_cls_nxt;
    sel_arr_r  <= sel_arr_nxt;
    sel_bur_r  <= sel_bur_nxt;
    start_r    <= start_nxt;
    finish_r   <= finish_nxt;
    tat_r      <= tat_nxt;
    wt_r       <= wt_nxt;
  end

  `TFS_NEVER(a_no_load_during_result, clk, rst_n, in_ch.ready && out_ch.valid, "load while busy")
  `TFS_ASSERT(a_result_in_batch, clk, rst_n, out_ch.valid |-> (cnt_r != '0), "empty batch")
  `TFS_ASSERT(a_final_clears, clk, rst_n, final_xfer |=> (cnt_r == '0 && done_r == '0), "no clear")
  `TFS_ASSERT(a_done_bounded, clk, rst_n, $countones(done_r) <= int'(cnt_r), "done overflow")

endmodule
